@@ rtl/hbm_pkg.sv @@
`default_nettype none

package hbm_pkg;

  // Default table sizes.
  localparam int LOCAL_NODES_DEF = 8;
  localparam int NET_NODES_DEF   = 8;

  // Field widths.
  localparam int MODE_W   = 2;
  localparam int NODE_W   = 8;
  localparam int AGE_W    = 8;
  localparam int SEQ_W    = 8;
  localparam int ID_W     = 11;
  localparam int PERIOD_W = 16;
  localparam int MAP_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOCAL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NET   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_ID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AGE_PERIOD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NET_PERIOD   = 3'd5;

  // Register reset values.
  localparam logic [3:0]          NODE_ADDR_RST    = 4'd0;
  localparam logic [2:0]          CLUSTER_ID_RST   = 3'd0;
  localparam logic [AGE_W-1:0]    STALE_LIMIT_RST  = 8'd5;
  localparam logic [PERIOD_W-1:0] LOCAL_PERIOD_RST = 16'd300;
  localparam logic [PERIOD_W-1:0] AGE_PERIOD_RST   = 16'd1000;
  localparam logic [PERIOD_W-1:0] NET_PERIOD_RST   = 16'd2000;

  // Heartbeat identifier parts and state reset values.
  localparam logic [ID_W-1:0]  HB_ID_BASE    = 11'h400;
  localparam logic [ID_W-1:0]  HB_ID_FUNC    = 11'h001;
  localparam logic [AGE_W-1:0] AGE_RST       = 8'hFF;
  localparam logic [SEQ_W-1:0] LOCAL_SEQ_RST = 8'd1;
  localparam logic [SEQ_W-1:0] NET_SEQ_RST   = 8'd0;

  // Configuration registers as one bundle.
  typedef struct packed {
    logic [3:0]          node_addr;
    logic [2:0]          cluster_id;
    logic [AGE_W-1:0]    stale_limit;
    logic [PERIOD_W-1:0] local_period;
    logic [PERIOD_W-1:0] age_period;
    logic [PERIOD_W-1:0] net_period;
  } hbm_cfg_t;

  // Events raised by the prescalers for one tick.
  typedef struct packed {
    logic             lsend;
    logic [SEQ_W-1:0] lseq;
    logic             nsend;
    logic [SEQ_W-1:0] nseq;
    logic             lage;
    logic             nage;
  } hbm_evt_t;

endpackage

`default_nettype wire

@@ rtl/hbm_if.sv @@
`default_nettype none

// Input item channel.
interface hbm_in_if;
  import hbm_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [NODE_W-1:0] node;
  modport source (output valid, mode, node, input ready);
  modport sink (input valid, mode, node, output ready);
endinterface

// Result item channel.
interface hbm_out_if;
  import hbm_pkg::*;
  logic             valid;
  logic             ready;
  logic [MAP_W-1:0] local_offline;
  logic [MAP_W-1:0] net_offline;
  logic             local_packet_valid;
  logic [ID_W-1:0]  local_packet_id;
  logic [SEQ_W-1:0] local_packet_seq;
  logic             net_packet_valid;
  logic [ID_W-1:0]  net_packet_id;
  logic [SEQ_W-1:0] net_packet_seq;
  modport source (output valid, local_offline, net_offline, local_packet_valid,
                  local_packet_id, local_packet_seq, net_packet_valid,
                  net_packet_id, net_packet_seq, input ready);
  modport sink (input valid, local_offline, net_offline, local_packet_valid,
                local_packet_id, local_packet_seq, net_packet_valid,
                net_packet_id, net_packet_seq, output ready);
endinterface

// Configuration write channel.
interface hbm_cfg_if;
  import hbm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/hbm_timers.sv @@
`default_nettype none

module hbm_timers (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             tick,
  input  wire hbm_pkg::hbm_cfg_t cfg,
  output hbm_pkg::hbm_evt_t     evt
);
  import hbm_pkg::*;

  logic [PERIOD_W-1:0] ltick_r, ltick_nxt, ntick_r, ntick_nxt;
  logic [PERIOD_W-1:0] lage_r, lage_nxt, nage_r, nage_nxt;
  logic [PERIOD_W-1:0] ltick_inc, ntick_inc, lage_inc, nage_inc;
  logic [SEQ_W-1:0]    lseq_r, lseq_nxt, nseq_r, nseq_nxt;
  logic                lfire, nfire, lage_fire, nage_fire, net_on;

  // Each prescaler fires once its incremented count reaches the period.
  always_comb begin
    ltick_inc = ltick_r + 16'd1;
    ntick_inc = ntick_r + 16'd1;
    lage_inc  = lage_r + 16'd1;
    nage_inc  = nage_r + 16'd1;
    lfire     = ltick_inc >= cfg.local_period;
    nfire     = ntick_inc >= cfg.net_period;
    lage_fire = lage_inc >= cfg.age_period;
    nage_fire = nage_inc >= cfg.net_period;
    net_on    = cfg.node_addr == 4'd0;

    ltick_nxt = ltick_r;
    ntick_nxt = ntick_r;
    lage_nxt  = lage_r;
    nage_nxt  = nage_r;
    if (tick) begin
      ltick_nxt = lfire ? '0 : ltick_inc;
      lage_nxt  = lage_fire ? '0 : lage_inc;
      nage_nxt  = nage_fire ? '0 : nage_inc;
      if (net_on) begin
        ntick_nxt = nfire ? '0 : ntick_inc;
      end
    end

    evt.lsend = tick && lfire;
    evt.lseq  = lseq_r;
    evt.nsend = tick && net_on && nfire;
    evt.nseq  = nseq_r;
    evt.lage  = tick && lage_fire;
    evt.nage  = tick && nage_fire;

    lseq_nxt = evt.lsend ? lseq_r + 8'd1 : lseq_r;
    nseq_nxt = evt.nsend ? nseq_r + 8'd1 : nseq_r;
  end

  // Counter and sequence registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ltick_r <= '0;
      ntick_r <= '0;
      lage_r  <= '0;
      nage_r  <= '0;
      lseq_r  <= LOCAL_SEQ_RST;
      nseq_r  <= NET_SEQ_RST;
    end else begin
      ltick_r <= ltick_nxt;
      ntick_r <= ntick_nxt;
      lage_r  <= lage_nxt;
      nage_r  <= nage_nxt;
      lseq_r  <= lseq_nxt;
      nseq_r  <= nseq_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/hbm_age_table.sv @@
`default_nettype none

module hbm_age_table #(
  parameter int N  = hbm_pkg::LOCAL_NODES_DEF,
  parameter int IW = (N > 1) ? $clog2(N) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    clr_en,
  input  wire logic [IW-1:0]           clr_idx,
  input  wire logic                    age_en,
  input  wire logic [hbm_pkg::AGE_W-1:0] stale_limit,
  output logic [hbm_pkg::MAP_W-1:0]    offline
);
  import hbm_pkg::*;

  logic [AGE_W-1:0] ages_r   [N];
  logic [AGE_W-1:0] ages_nxt [N];
  logic [AGE_W-1:0] cleared  [N];

  // Clear the addressed node first, then age every node below the limit.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      cleared[i] = (clr_en && (clr_idx == IW'(i))) ? '0 : ages_r[i];
      ages_nxt[i] = (age_en && (cleared[i] < stale_limit)) ? cleared[i] + 8'd1
                                                          : cleared[i];
    end
  end

  // Offline bitmap of the updated ages; only the first eight nodes show.
  always_comb begin
    offline = '0;
    for (int i = 0; i < MAP_W; i++) begin
      if (i < N) begin
        offline[i] = ages_nxt[i] >= stale_limit;
      end
    end
  end

  // Age registers start with every node offline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        ages_r[i] <= AGE_RST;
      end
    end else begin
      for (int i = 0; i < N; i++) begin
        ages_r[i] <= ages_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/heartbeat_sender_and_node_monitor_unit.sv @@
// An accepted item waits in the input register and is loaded into the result register as
// soon as that register is empty or its result is being taken.
// Throughput is one item per cycle while the receiver takes each result. All prescalers,
// sequences and age tables update in the cycle the item leaves the input register.
// Reset (rst_n low, synchronous) restores the register defaults, zeroes the
// prescalers, sets the sequences to 1 and 0 and marks every node offline.
`default_nettype none

module heartbeat_sender_and_node_monitor_unit #(
  parameter int LOCAL_NODES = hbm_pkg::LOCAL_NODES_DEF,
  parameter int NET_NODES   = hbm_pkg::NET_NODES_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  hbm_in_if.sink    in_bus,
  hbm_out_if.source out_bus,
  hbm_cfg_if.sink   cfg_bus
);
  import hbm_pkg::*;

  localparam int LIW = (LOCAL_NODES > 1) ? $clog2(LOCAL_NODES) : 1;
  localparam int NIW = (NET_NODES > 1) ? $clog2(NET_NODES) : 1;

  hbm_cfg_t          cfg_r;
  logic              in_vld_r;
  logic [MODE_W-1:0] mode_r;
  logic [NODE_W-1:0] node_r;
  logic              out_vld_r;
  logic              adv, proc_en, in_acc, tick;
  hbm_evt_t          evt;
  logic              lclr_en, nclr_en;
  logic [LIW-1:0]    lclr_idx;
  logic [NIW-1:0]    nclr_idx;
  logic [MAP_W-1:0]  loff, noff;
  logic [ID_W-1:0]   lid, nid;

  // Configuration writes are always taken.
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_addr    <= NODE_ADDR_RST;
      cfg_r.cluster_id   <= CLUSTER_ID_RST;
      cfg_r.stale_limit  <= STALE_LIMIT_RST;
      cfg_r.local_period <= LOCAL_PERIOD_RST;
      cfg_r.age_period   <= AGE_PERIOD_RST;
      cfg_r.net_period   <= NET_PERIOD_RST;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        REG_NODE_ADDR:    cfg_r.node_addr    <= cfg_bus.data[3:0];
        REG_CLUSTER_ID:   cfg_r.cluster_id   <= cfg_bus.data[2:0];
        REG_STALE_LIMIT:  cfg_r.stale_limit  <= cfg_bus.data[AGE_W-1:0];
        REG_LOCAL_PERIOD: cfg_r.local_period <= cfg_bus.data;
        REG_AGE_PERIOD:   cfg_r.age_period   <= cfg_bus.data;
        REG_NET_PERIOD:   cfg_r.net_period   <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result register frees.
  assign adv          = !out_vld_r || out_bus.ready;
  assign proc_en      = in_vld_r && adv;
  assign in_bus.ready = !in_vld_r || adv;
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign tick         = proc_en && (mode_r == MODE_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (proc_en) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_bus.mode;
      node_r <= in_bus.node;
    end
  end

  hbm_timers u_timers (
    .clk   (clk),
    .rst_n (rst_n),
    .tick  (tick),
    .cfg   (cfg_r),
    .evt   (evt)
  );

  // Clear own address on a local send, own cluster on net aging, else the heard node.
  always_comb begin
    lclr_en  = 1'b0;
    lclr_idx = node_r[LIW-1:0];
    nclr_en  = 1'b0;
    nclr_idx = node_r[NIW-1:0];
    if (tick) begin
      lclr_en  = evt.lsend && ({1'b0, cfg_r.node_addr} < 5'(LOCAL_NODES));
      lclr_idx = cfg_r.node_addr[LIW-1:0];
      nclr_en  = evt.nage && ({1'b0, cfg_r.cluster_id} < 4'(NET_NODES));
      nclr_idx = cfg_r.cluster_id[NIW-1:0];
    end else if (proc_en && (mode_r == MODE_LOCAL)) begin
      lclr_en = node_r < NODE_W'(LOCAL_NODES);
    end else if (proc_en && (mode_r == MODE_NET)) begin
      nclr_en = node_r < NODE_W'(NET_NODES);
    end
  end

  hbm_age_table #(
    .N  (LOCAL_NODES),
    .IW (LIW)
  ) u_local_ages (
    .clk         (clk),
    .rst_n       (rst_n),
    .clr_en      (lclr_en),
    .clr_idx     (lclr_idx),
    .age_en      (evt.lage),
    .stale_limit (cfg_r.stale_limit),
    .offline     (loff)
  );

  hbm_age_table #(
    .N  (NET_NODES),
    .IW (NIW)
  ) u_net_ages (
    .clk         (clk),
    .rst_n       (rst_n),
    .clr_en      (nclr_en),
    .clr_idx     (nclr_idx),
    .age_en      (evt.nage),
    .stale_limit (cfg_r.stale_limit),
    .offline     (noff)
  );

  // Packet identifiers; the network packet carries node address zero.
  assign lid = HB_ID_BASE | HB_ID_FUNC | (ID_W'(cfg_r.node_addr) << 3)
             | (ID_W'(cfg_r.cluster_id) << 7);
  assign nid = HB_ID_BASE | HB_ID_FUNC | (ID_W'(cfg_r.cluster_id) << 7);

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc_en) begin
      out_vld_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en) begin
      out_bus.local_offline      <= loff;
      out_bus.net_offline        <= noff;
      out_bus.local_packet_valid <= evt.lsend;
      out_bus.local_packet_id    <= evt.lsend ? lid : '0;
      out_bus.local_packet_seq   <= evt.lsend ? evt.lseq : '0;
      out_bus.net_packet_valid   <= evt.nsend;
      out_bus.net_packet_id      <= evt.nsend ? nid : '0;
      out_bus.net_packet_seq     <= evt.nsend ? evt.nseq : '0;
    end
  end

  assign out_bus.valid = out_vld_r;

  // Every item taken from the input register yields a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    proc_en |=> out_vld_r)
    else $error("processed item left no result");

  // Network heartbeats are sent only by node address zero.
  a_net_send_owner: assert property (@(posedge clk) disable iff (!rst_n)
    evt.nsend |-> (cfg_r.node_addr == 4'd0) && tick)
    else $error("network heartbeat from a non-zero node address");

  // A result without a local packet carries a zero id and sequence.
  a_local_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_bus.local_packet_valid) |->
      (out_bus.local_packet_id == '0) && (out_bus.local_packet_seq == '0))
    else $error("local packet fields set without a packet");

endmodule

`default_nettype wire

@@ sim/heartbeat_sender_and_node_monitor_unit_test.sv @@
`default_nettype none

module heartbeat_sender_and_node_monitor_unit_test;
  import hbm_pkg::*;

  localparam int LOCAL_N = LOCAL_NODES_DEF;
  localparam int NET_N   = NET_NODES_DEF;

  // Codes the block ignores: an unused mode and two unused register indexes.
  localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  // One status item as the block reports it.
  typedef struct packed {
    logic [MAP_W-1:0] local_offline;
    logic [MAP_W-1:0] net_offline;
    logic             local_packet_valid;
    logic [ID_W-1:0]  local_packet_id;
    logic [SEQ_W-1:0] local_packet_seq;
    logic             net_packet_valid;
    logic [ID_W-1:0]  net_packet_id;
    logic [SEQ_W-1:0] net_packet_seq;
  } hb_status_t;

  typedef logic [7:0][AGE_W-1:0] age_table_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hbm_in_if  in_ch ();
  hbm_out_if out_ch ();
  hbm_cfg_if cfg_ch ();

  heartbeat_sender_and_node_monitor_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch),
    .cfg_bus(cfg_ch)
  );

  always #5 clk = ~clk;

  // Predicted register contents.
  logic [3:0]          cfg_node_addr;
  logic [2:0]          cfg_cluster_id;
  logic [AGE_W-1:0]    cfg_stale_limit;
  logic [PERIOD_W-1:0] cfg_local_period;
  logic [PERIOD_W-1:0] cfg_age_period;
  logic [PERIOD_W-1:0] cfg_net_period;

  // Predicted prescalers, sequence numbers and age tables.
  logic [PERIOD_W-1:0] local_send_cnt;
  logic [PERIOD_W-1:0] net_send_cnt;
  logic [PERIOD_W-1:0] local_age_cnt;
  logic [PERIOD_W-1:0] net_age_cnt;
  logic [SEQ_W-1:0]    local_seq;
  logic [SEQ_W-1:0]    net_seq;
  age_table_t          local_ages;
  age_table_t          net_ages;

  hb_status_t expected_status[$];
  int         mismatch_count = 0;

  // Traffic shaping knobs, all in percent or cycles.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_cycles = 0;

  // A prescaler fires once its incremented count reaches the period.
  task automatic advance_prescaler(inout logic [PERIOD_W-1:0] cnt,
                                   input logic [PERIOD_W-1:0] period, output bit fired);
    cnt = cnt + 16'd1;
    fired = (cnt >= period);
    if (fired) begin
      cnt = '0;
    end
  endtask

  // Ages saturate at the stale limit.
  task automatic age_step(inout age_table_t ages, input int n);
    for (int i = 0; i < n; i++) begin
      if (ages[i] < cfg_stale_limit) begin
        ages[i] = ages[i] + 8'd1;
      end
    end
  endtask

  function automatic logic [MAP_W-1:0] offline_bits(age_table_t ages, int n);
    logic [MAP_W-1:0] m;
    m = '0;
    for (int i = 0; i < n && i < MAP_W; i++) begin
      if (ages[i] >= cfg_stale_limit) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

  task automatic reset_model();
    cfg_node_addr    = NODE_ADDR_RST;
    cfg_cluster_id   = CLUSTER_ID_RST;
    cfg_stale_limit  = STALE_LIMIT_RST;
    cfg_local_period = LOCAL_PERIOD_RST;
    cfg_age_period   = AGE_PERIOD_RST;
    cfg_net_period   = NET_PERIOD_RST;
    local_send_cnt   = '0;
    net_send_cnt     = '0;
    local_age_cnt    = '0;
    net_age_cnt      = '0;
    local_seq        = LOCAL_SEQ_RST;
    net_seq          = NET_SEQ_RST;
    for (int i = 0; i < 8; i++) begin
      local_ages[i] = AGE_RST;
      net_ages[i]   = AGE_RST;
    end
  endtask

  // Work out the status item that one event produces and queue it.
  task automatic model_event(input logic [MODE_W-1:0] mode, input logic [NODE_W-1:0] node);
    hb_status_t s;
    bit fired;
    s = '0;
    case (mode)
      MODE_TICK: begin
        // The network sender runs first and only on node address zero.
        if (cfg_node_addr == 4'd0) begin
          advance_prescaler(net_send_cnt, cfg_net_period, fired);
          if (fired) begin
            s.net_packet_valid = 1'b1;
            s.net_packet_id    = HB_ID_BASE | HB_ID_FUNC | ID_W'({cfg_cluster_id, 7'd0});
            s.net_packet_seq   = net_seq;
            net_seq            = net_seq + 8'd1;
          end
        end
        advance_prescaler(local_send_cnt, cfg_local_period, fired);
        if (fired) begin
          s.local_packet_valid = 1'b1;
          s.local_packet_id    = HB_ID_BASE | HB_ID_FUNC |
                                 ID_W'({cfg_cluster_id, cfg_node_addr, 3'd0});
          s.local_packet_seq   = local_seq;
          local_seq            = local_seq + 8'd1;
          if ({1'b0, cfg_node_addr} < 5'(LOCAL_N)) begin
            local_ages[cfg_node_addr[2:0]] = '0;
          end
        end
        advance_prescaler(local_age_cnt, cfg_age_period, fired);
        if (fired) begin
          age_step(local_ages, LOCAL_N);
        end
        // The own cluster is cleared just before the network aging.
        advance_prescaler(net_age_cnt, cfg_net_period, fired);
        if (fired) begin
          if ({1'b0, cfg_cluster_id} < 4'(NET_N)) begin
            net_ages[cfg_cluster_id] = '0;
          end
          age_step(net_ages, NET_N);
        end
      end
      MODE_LOCAL: begin
        if (node < NODE_W'(LOCAL_N)) begin
          local_ages[node[2:0]] = '0;
        end
      end
      MODE_NET: begin
        if (node < NODE_W'(NET_N)) begin
          net_ages[node[2:0]] = '0;
        end
      end
      default: begin
      end
    endcase
    s.local_offline = offline_bits(local_ages, LOCAL_N);
    s.net_offline   = offline_bits(net_ages, NET_N);
    expected_status.push_back(s);
  endtask

  // Offer one item at the falling edge and hold it until it is taken.
  task automatic send_event(input logic [MODE_W-1:0] mode, input logic [NODE_W-1:0] node);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.mode  = mode;
    in_ch.node  = node;
    do begin
      @(posedge clk);
    end while (in_ch.ready !== 1'b1);
    model_event(mode, node);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do begin
      @(posedge clk);
    end while (cfg_ch.ready !== 1'b1);
    case (idx)
      REG_NODE_ADDR:    cfg_node_addr    = data[3:0];
      REG_CLUSTER_ID:   cfg_cluster_id   = data[2:0];
      REG_STALE_LIMIT:  cfg_stale_limit  = data[AGE_W-1:0];
      REG_LOCAL_PERIOD: cfg_local_period = data;
      REG_AGE_PERIOD:   cfg_age_period   = data;
      REG_NET_PERIOD:   cfg_net_period   = data;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_for_drain();
    while (expected_status.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_all(input logic [15:0] node_addr, input logic [15:0] cluster,
                           input logic [15:0] stale, input logic [15:0] lper,
                           input logic [15:0] aper, input logic [15:0] nper);
    wait_for_drain();
    write_register(REG_NODE_ADDR, node_addr);
    write_register(REG_CLUSTER_ID, cluster);
    write_register(REG_STALE_LIMIT, stale);
    write_register(REG_LOCAL_PERIOD, lper);
    write_register(REG_AGE_PERIOD, aper);
    write_register(REG_NET_PERIOD, nper);
  endtask

  // Mostly short periods so packets and aging happen often.
  function automatic logic [15:0] pick_period();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [15:0] pick_stale();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'd255;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  // Random event: mostly ticks and heard nodes near the table range.
  task automatic send_random_event();
    logic [MODE_W-1:0] mode;
    logic [NODE_W-1:0] node;
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      mode = MODE_TICK;
    end else if (r < 70) begin
      mode = MODE_LOCAL;
    end else if (r < 95) begin
      mode = MODE_NET;
    end else begin
      mode = MODE_UNUSED;
    end
    node = ($urandom_range(4) == 0) ? NODE_W'($urandom_range(255)) :
                                       NODE_W'($urandom_range(9));
    send_event(mode, node);
  endtask

  // Default registers: every node starts offline, unused mode, out-of-range nodes.
  task automatic test_after_reset();
    send_event(MODE_UNUSED, 8'd0);
    send_event(MODE_LOCAL, 8'd0);
    send_event(MODE_LOCAL, 8'd7);
    send_event(MODE_LOCAL, 8'd8);
    send_event(MODE_NET, 8'd0);
    send_event(MODE_NET, 8'd7);
    send_event(MODE_NET, 8'd255);
    send_event(MODE_TICK, 8'd255);
  endtask

  // Register extremes: periods of one, zero and the maximum, stale limits 1, 0, 255.
  task automatic test_register_extremes();
    write_all(16'd0, 16'd7, 16'd1, 16'd1, 16'd1, 16'd1);
    repeat (4) send_event(MODE_TICK, 8'd0);
    write_all(16'hFFFF, 16'hFFF8, 16'hFF00, 16'd0, 16'd0, 16'd0);
    write_register(REG_SPARE_6, 16'hFFFF);
    write_register(REG_SPARE_7, 16'h5A5A);
    repeat (3) send_event(MODE_TICK, 8'd0);
    send_event(MODE_LOCAL, 8'd255);
    write_all(16'd7, 16'd3, 16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_event(MODE_LOCAL, 8'd3);
    repeat (2) send_event(MODE_TICK, 8'd128);
  endtask

  // Random settings, each followed by a stretch of random events.
  task automatic test_random_traffic(input int settings, input int per_setting);
    repeat (settings) begin
      write_all(($urandom_range(1) == 0) ? 16'd0 : 16'($urandom),
                16'($urandom), pick_stale(), pick_period(), pick_period(), pick_period());
      repeat (per_setting) send_random_event();
    end
  endtask

  // Long receiver stall while items keep coming, so the input backs up.
  task automatic test_backpressure();
    write_all(16'd0, 16'd2, 16'd3, 16'd2, 16'd1, 16'd3);
    rx_hold_cycles = 120;
    repeat (30) send_random_event();
  endtask

  // The sender stops until every result is back, then resumes.
  task automatic test_drain_pause();
    repeat (15) send_random_event();
    wait_for_drain();
    repeat (15) send_random_event();
  endtask

  // Enough packets on every tick for both sequence numbers to wrap.
  task automatic test_sequence_wrap();
    write_all(16'd0, 16'd5, 16'd3, 16'd1, 16'd2, 16'd1);
    repeat (260) send_event(MODE_TICK, NODE_W'($urandom_range(255)));
  endtask

  // Receiver readiness, with an optional long hold-off.
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      out_ch.ready = 1'b0;
      rx_hold_cycles = rx_hold_cycles - 1;
    end else begin
      out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    hb_status_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_status.size() == 0) begin
        $display("%0t: result with no item outstanding", $time);
        mismatch_count++;
      end else begin
        want = expected_status.pop_front();
        check_field("local_offline", 16'(want.local_offline), 16'(out_ch.local_offline));
        check_field("net_offline", 16'(want.net_offline), 16'(out_ch.net_offline));
        check_field("local_packet_valid", 16'(want.local_packet_valid),
                    16'(out_ch.local_packet_valid));
        check_field("local_packet_id", 16'(want.local_packet_id),
                    16'(out_ch.local_packet_id));
        check_field("local_packet_seq", 16'(want.local_packet_seq),
                    16'(out_ch.local_packet_seq));
        check_field("net_packet_valid", 16'(want.net_packet_valid),
                    16'(out_ch.net_packet_valid));
        check_field("net_packet_id", 16'(want.net_packet_id), 16'(out_ch.net_packet_id));
        check_field("net_packet_seq", 16'(want.net_packet_seq),
                    16'(out_ch.net_packet_seq));
      end
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_TICK;
    in_ch.node   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_NODE_ADDR;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
    reset_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    tx_idle_pct = 19;
    rx_idle_pct = 67;
    test_after_reset();
    test_register_extremes();
    test_random_traffic(2, 40);

    tx_idle_pct = 67;
    rx_idle_pct = 19;
    test_random_traffic(2, 40);
    test_backpressure();
    test_drain_pause();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_sequence_wrap();
    test_random_traffic(2, 40);

    // Let the last results arrive and make sure nothing extra follows.
    wait_for_drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
